>>> rtl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg: shared types and constants of the streaming SHA-256 hasher
// Holds the block and digest word types, the buffer command interface, the
// compression control and status groups, the round constants and the
// initial hash value.
// ----------------------------------------------------------------------------
package shs_pkg;

    // Sixteen 32-bit message words; index 0 holds the first word of the block.
    typedef logic [15:0][31:0] shs_block_t;

    // Eight 32-bit words; index 0 is H0 (or working variable a).
    typedef logic [7:0][31:0] shs_words8_t;

    // Commands to the block buffer.
    typedef enum logic [1:0] {
        BUF_NONE   = 2'd0,
        BUF_ABSORB = 2'd1,
        BUF_PAD    = 2'd2,
        BUF_LEN    = 2'd3
    } shs_buf_op_t;

    typedef struct packed {
        shs_buf_op_t op;
        logic [5:0]  pos;
        logic [2:0]  nbytes;
        logic [31:0] word;
    } shs_buf_cmd_t;

    // Control and status between the sequencer and the compression unit.
    typedef struct packed {
        logic start;
        logic reinit;
    } shs_cmp_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } shs_cmp_stat_t;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LENGTH_POS = 6'd56;

    // Initial hash value, listed from H7 down to H0.
    localparam shs_words8_t INIT_H = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

>>> rtl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher: streaming SHA-256 hasher
// Takes big-endian message words with a valid byte count, pads the final
// block and streams out the eight digest words.
// ----------------------------------------------------------------------------
// A word is packed into the block buffer in the cycle after it is taken, and
// no new word is taken until that is done. Each time the block fills, the
// single round unit runs a start step, 64 rounds and a chaining add, and no
// new word is taken meanwhile; any leftover bytes are then placed in the new
// block. The final word adds one or two padded blocks, each after its padding
// write, and then 8 output items, H0 first, with tlast on the eighth; s_tready
// stays low from the accepted word until its work, including the digest
// output, is finished.
module sha256_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] message_word, [34:32] valid_bytes, [39:35] zero
    input  logic        s_tlast,   // final_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic        m_tlast    // last_digest_word
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_ABSORB = 7'b0000010,
        ST_KICK   = 7'b0000100,
        ST_COMP   = 7'b0001000,
        ST_PAD    = 7'b0010000,
        ST_PAD2   = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    state_t      after_reg, after_next;
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] len_reg, len_next;
    logic [2:0]  idx_reg, idx_next;
    logic [31:0] word_reg, word_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        fin_reg, fin_next;

    logic                   in_accept;
    logic [2:0]             in_count;
    logic [6:0]             room;
    logic [2:0]             take;
    logic [6:0]             fill;
    shs_pkg::shs_buf_cmd_t  buf_cmd;
    shs_pkg::shs_cmp_ctl_t  cmp_ctl;
    shs_pkg::shs_cmp_stat_t cmp_stat;
    shs_pkg::shs_block_t    blk;
    shs_pkg::shs_words8_t   chain;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // Counts above four mean a full word.
    assign in_count = (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];

    // Bytes of the held word that fit before the block is full.
    assign room = 7'd64 - {1'b0, pos_reg};
    assign take = ({4'b0000, cnt_reg} <= room) ? cnt_reg : room[2:0];
    assign fill = {1'b0, pos_reg} + {4'b0000, take};

    // Main sequencer.
    always_comb begin
        state_next     = state_reg;
        after_next     = after_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        word_next      = word_reg;
        cnt_next       = cnt_reg;
        fin_next       = fin_reg;
        buf_cmd.op     = shs_pkg::BUF_NONE;
        buf_cmd.pos    = pos_reg;
        buf_cmd.nbytes = take;
        buf_cmd.word   = word_reg;
        cmp_ctl.start  = 1'b0;
        cmp_ctl.reinit = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    word_next  = s_tdata[31:0];
                    cnt_next   = in_count;
                    fin_next   = s_tlast;
                    len_next   = len_reg + {58'd0, in_count, 3'b000};
                    state_next = ST_ABSORB;
                end
            end
            ST_ABSORB: begin
                buf_cmd.op = shs_pkg::BUF_ABSORB;
                pos_next   = fill[5:0];
                word_next  = word_reg << {take, 3'b000};
                cnt_next   = cnt_reg - take;
                if (fill[6]) begin
                    // Block is full: compress, then place any leftover bytes.
                    after_next = ST_ABSORB;
                    state_next = ST_KICK;
                end else if (fin_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_KICK: begin
                cmp_ctl.start = 1'b1;
                state_next    = ST_COMP;
            end
            ST_COMP: begin
                if (cmp_stat.done) begin
                    state_next = after_reg;
                end
            end
            ST_PAD: begin
                buf_cmd.op = shs_pkg::BUF_PAD;
                pos_next   = '0;
                after_next = (pos_reg < shs_pkg::LENGTH_POS) ? ST_OUT : ST_PAD2;
                state_next = ST_KICK;
            end
            ST_PAD2: begin
                buf_cmd.op = shs_pkg::BUF_LEN;
                after_next = ST_OUT;
                state_next = ST_KICK;
            end
            ST_OUT: begin
                if (m_tready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        cmp_ctl.reinit = 1'b1;
                        len_next       = '0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            after_reg <= ST_IDLE;
            pos_reg   <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            after_reg <= after_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
        end
    end

    // Held input item.
    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        cnt_reg  <= cnt_next;
        fin_reg  <= fin_next;
    end

    shs_block_buf u_buf (
        .aclk   (aclk),
        .cmd    (buf_cmd),
        .length (len_reg),
        .blk    (blk)
    );

    shs_compress u_cmp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (cmp_ctl),
        .blk     (blk),
        .stat    (cmp_stat),
        .chain   (chain)
    );

    // Digest output straight from the chaining registers.
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = chain[idx_reg];
    assign m_tlast  = (idx_reg == 3'd7);

    // Input and output are never open at the same time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while digest output is pending");

    // A compression is only started while the round unit is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KICK) |-> !cmp_stat.busy)
        else $error("compression started while round unit busy");

    // The round unit finishes only while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_stat.done |-> (state_reg == ST_COMP))
        else $error("compression finished outside wait state");

    // After the last digest item the block takes input again.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("block not ready after digest output");

endmodule

>>> rtl/shs_block_buf.sv
// ----------------------------------------------------------------------------
// shs_block_buf: 64-byte message block buffer
// Writes message bytes at any byte position, applies the padding byte and
// zero fill, and places the 64-bit message length in the last two words.
// ----------------------------------------------------------------------------
module shs_block_buf (
    input  logic                 aclk,
    input  shs_pkg::shs_buf_cmd_t cmd,
    input  logic [63:0]          length,
    output shs_pkg::shs_block_t  blk
);

    shs_pkg::shs_block_t blk_reg;
    shs_pkg::shs_block_t blk_next;

    // Byte-wise update of the block for the current command.
    always_comb begin
        logic [6:0]  off;
        logic [31:0] shifted;
        blk_next = blk_reg;
        off      = '0;
        shifted  = '0;
        case (cmd.op)
            shs_pkg::BUF_ABSORB: begin
                for (int j = 0; j < 64; j++) begin
                    off     = 7'(j) - {1'b0, cmd.pos};
                    shifted = cmd.word << {off[1:0], 3'b000};
                    if ((7'(j) >= {1'b0, cmd.pos}) && (off < {4'b0000, cmd.nbytes})) begin
                        blk_next[j >> 2][8 * (3 - (j & 3)) +: 8] = shifted[31:24];
                    end
                end
            end
            shs_pkg::BUF_PAD: begin
                for (int j = 0; j < 64; j++) begin
                    if (6'(j) == cmd.pos) begin
                        blk_next[j >> 2][8 * (3 - (j & 3)) +: 8] = shs_pkg::PAD_BYTE;
                    end else if (6'(j) > cmd.pos) begin
                        blk_next[j >> 2][8 * (3 - (j & 3)) +: 8] = 8'h00;
                    end
                end
                // The length fits behind the padding byte in this block.
                if (cmd.pos < shs_pkg::LENGTH_POS) begin
                    blk_next[14] = length[63:32];
                    blk_next[15] = length[31:0];
                end
            end
            shs_pkg::BUF_LEN: begin
                for (int w = 0; w < 14; w++) begin
                    blk_next[w] = '0;
                end
                blk_next[14] = length[63:32];
                blk_next[15] = length[31:0];
            end
            default: begin
                blk_next = blk_reg;
            end
        endcase
    end

    // Block storage; contents are fully written before each compression.
    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
    end

    assign blk = blk_reg;

endmodule

>>> rtl/shs_compress.sv
// ----------------------------------------------------------------------------
// shs_compress: iterative SHA-256 compression unit
// One shared round datapath runs 64 rounds, one per cycle, with a 16-word
// sliding message schedule, then adds the working variables into the
// chaining value.
// ----------------------------------------------------------------------------
module shs_compress (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  shs_pkg::shs_cmp_ctl_t ctl,
    input  shs_pkg::shs_block_t   blk,
    output shs_pkg::shs_cmp_stat_t stat,
    output shs_pkg::shs_words8_t  chain
);

    typedef enum logic [2:0] {
        CMP_IDLE  = 3'b001,
        CMP_ROUND = 3'b010,
        CMP_FINAL = 3'b100
    } cmp_state_t;

    cmp_state_t           state_reg, state_next;
    logic [5:0]           rnd_reg, rnd_next;
    shs_pkg::shs_words8_t chain_reg, chain_next;
    shs_pkg::shs_words8_t v_reg, v_next;
    shs_pkg::shs_block_t  w_reg, w_next;

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    // Round datapath and sequencing.
    always_comb begin
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] choose;
        logic [31:0] major;
        state_next = state_reg;
        rnd_next   = rnd_reg;
        chain_next = chain_reg;
        v_next     = v_reg;
        w_next     = w_reg;
        choose = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        major  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1     = v_reg[7] + big_sigma1(v_reg[4]) + choose + shs_pkg::ROUND_K[rnd_reg]
                 + w_reg[0];
        t2     = big_sigma0(v_reg[0]) + major;
        unique case (state_reg)
            CMP_IDLE: begin
                if (ctl.start) begin
                    w_next     = blk;
                    v_next     = chain_reg;
                    rnd_next   = '0;
                    state_next = CMP_ROUND;
                end else if (ctl.reinit) begin
                    chain_next = shs_pkg::INIT_H;
                end
            end
            CMP_ROUND: begin
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                // Slide the schedule window and form the next schedule word.
                for (int i = 0; i < 15; i++) begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[15] = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1])
                             + w_reg[0];
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    state_next = CMP_FINAL;
                end
            end
            CMP_FINAL: begin
                for (int i = 0; i < 8; i++) begin
                    chain_next[i] = chain_reg[i] + v_reg[i];
                end
                state_next = CMP_IDLE;
            end
            default: begin
                state_next = CMP_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CMP_IDLE;
            rnd_reg   <= '0;
            chain_reg <= shs_pkg::INIT_H;
        end else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            chain_reg <= chain_next;
        end
    end

    // Working variables and schedule window carry no reset.
    always_ff @(posedge aclk) begin
        v_reg <= v_next;
        w_reg <= w_next;
    end

    assign stat.busy = (state_reg != CMP_IDLE);
    assign stat.done = (state_reg == CMP_FINAL);
    assign chain     = chain_reg;

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the streaming SHA-256 hasher
// Feeds directed and random messages as big-endian words with byte counts,
// predicts the eight digest words of every message in a scoreboard with its
// own SHA-256 implementation, and checks each digest item on the output.
// ----------------------------------------------------------------------------
module tb;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 6;
    localparam int ITEMS_PER_PHASE = 45;
    localparam int TAIL_CYCLES     = 200;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int SHOWN_ERRORS    = 10;

    // Predicts digests from accepted words and checks the digest items.
    class digest_scoreboard;
        bit [31:0]   chain [8];
        bit [7:0]    blk_bytes [64];
        int unsigned fill;
        bit [63:0]   bit_len;
        bit [31:0]   want_word [$];
        bit          want_last [$];
        int unsigned errors;

        function new();
            errors = 0;
            restart();
        endfunction

        // Back to the initial hash value with an empty buffer.
        function void restart();
            for (int i = 0; i < 8; i++) chain[i] = shs_pkg::INIT_H[i];
            fill    = 0;
            bit_len = '0;
        endfunction

        function bit [31:0] rotr(bit [31:0] x, int unsigned n);
            return (x >> n) | (x << (32 - n));
        endfunction

        // One 64-round compression of the buffered block into the chain.
        function void compress();
            bit [31:0] sched [64];
            bit [31:0] v [8];
            bit [31:0] s0, s1, t1, t2;
            for (int i = 0; i < 16; i++) begin
                sched[i] = {blk_bytes[4*i], blk_bytes[4*i+1],
                            blk_bytes[4*i+2], blk_bytes[4*i+3]};
            end
            for (int i = 16; i < 64; i++) begin
                s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
                s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
                sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
            end
            v = chain;
            for (int r = 0; r < 64; r++) begin
                s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
                t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + shs_pkg::ROUND_K[r]
                     + sched[r];
                s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
                t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) chain[i] += v[i];
        endfunction

        // Appends one byte; a full block is compressed at once.
        function void push_byte(bit [7:0] b);
            blk_bytes[fill] = b;
            fill++;
            if (fill == 64) begin
                compress();
                fill = 0;
            end
        endfunction

        // Notes an accepted item; a final word pads the message and queues its digest.
        function void note_word(bit [31:0] word, bit [2:0] nbytes, bit fin);
            int unsigned take;
            take = (nbytes > 3'd4) ? 4 : nbytes;
            for (int i = 0; i < take; i++) push_byte(word[31 - 8*i -: 8]);
            bit_len += 64'(take * 8);
            if (!fin) return;
            // Padding marker, zeros up to the length field, then the bit length.
            push_byte(shs_pkg::PAD_BYTE);
            while (fill != shs_pkg::LENGTH_POS) push_byte(8'h00);
            for (int i = 0; i < 8; i++) push_byte(bit_len[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++) begin
                want_word.push_back(chain[i]);
                want_last.push_back(i == 7);
            end
            restart();
        endfunction

        // Compares one digest item with the oldest expected one.
        function void check_digest(logic [31:0] got_word, logic got_last);
            bit [31:0] exp_word;
            bit        exp_last;
            if (want_word.size() == 0) begin
                errors++;
                if (errors <= SHOWN_ERRORS) begin
                    $display("unexpected digest item: word %h last %b", got_word, got_last);
                end
                return;
            end
            exp_word = want_word.pop_front();
            exp_last = want_last.pop_front();
            if (got_word !== exp_word || got_last !== exp_last) begin
                errors++;
                if (errors <= SHOWN_ERRORS) begin
                    $display("digest mismatch: expected word %h last %b, got word %h last %b",
                             exp_word, exp_last, got_word, got_last);
                end
            end
        endfunction

        function int unsigned pending();
            return want_word.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // [31:0] message_word, [34:32] valid_bytes, [39:35] zero
    logic        s_tlast  = 1'b0; // final_word
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] digest_word
    logic        m_tlast;         // last_digest_word

    digest_scoreboard sb = new();
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned phase_items    = 0;
    int unsigned cycle_count    = 0;

    sha256_stream_hasher u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Guard against a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Digest side: check every accepted item, then pick the next ready value.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_digest(m_tdata, m_tlast);
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offers one message word, with random idle cycles ahead of it.
    task automatic send_word(input bit [31:0] word, input bit [2:0] nbytes, input bit fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, nbytes, word};
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(word, nbytes, fin);
        phase_items++;
    endtask

    // Mostly well-formed messages around the padding boundaries, some broken ones.
    task automatic send_message();
        int unsigned kind;
        int unsigned pick;
        int unsigned nfull;
        int unsigned last_count;
        kind = $urandom_range(99);
        if (kind < 80) begin
            pick = $urandom_range(99);
            if (pick < 60) nfull = $urandom_range(0, 5);
            else if (pick < 85) nfull = $urandom_range(12, 17);
            else nfull = $urandom_range(18, 40);
            for (int i = 0; i < nfull; i++) send_word($urandom, 3'd4, 1'b0);
            last_count = ($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
            send_word($urandom, 3'(last_count), 1'b1);
        end else begin
            // Partial words and oversized counts in the middle of a message.
            nfull = $urandom_range(0, 12);
            for (int i = 0; i < nfull; i++) send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
            send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
        end
    endtask

    // Main sequence: reset, directed messages, then four phases of input idling and output stalls.
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty message: an empty final word alone.
        send_word(32'h0000_0000, 3'd0, 1'b1);
        // Three-byte message; the byte beyond the count must be ignored.
        send_word(32'h6162_63ff, 3'd3, 1'b1);
        // Counts above four are taken as four.
        send_word(32'hffff_ffff, 3'd7, 1'b0);
        send_word(32'h0000_0000, 3'd5, 1'b0);
        send_word(32'ha5a5_a5a5, 3'd6, 1'b1);
        // Partial and empty words before the final one.
        send_word(32'h1234_5678, 3'd1, 1'b0);
        send_word(32'h9abc_def0, 3'd2, 1'b0);
        send_word(32'hffff_ffff, 3'd0, 1'b0);
        send_word(32'h0f0f_0f0f, 3'd3, 1'b1);
        // 55 bytes: the padding marker and length still fit into one block.
        for (int i = 0; i < 13; i++) send_word($urandom, 3'd4, 1'b0);
        send_word($urandom, 3'd3, 1'b1);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) send_message();
            // Hold the input off until every digest of the phase is out.
            s_tvalid <= 1'b0;
            while (sb.pending() != 0) @(posedge aclk);
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
